### rtl/assert_macros.svh
// Assertion macros for the port-level checker of the merge engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define KWM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define KWM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### rtl/kwm_pkg.sv
// Types and codes shared by the merge engine and its checker.
`timescale 1ns / 1ps

package kwm_pkg;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;

  localparam logic [2:0] ST_CLEARED  = 3'd0;
  localparam logic [2:0] ST_LOADED   = 3'd1;
  localparam logic [2:0] ST_POPPED   = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic [3:0] ACTIVE_RESET = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_WR,
    S_SC_HEAD,
    S_SC_CMP,
    S_SC_END
  } state_t;

endpackage

### rtl/kwm_key_store.sv
// Key storage RAM holding every channel's circular queue.
`timescale 1ns / 1ps

module kwm_key_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/kwm_queue_table.sv
// Per-channel head and fill table with valid bits that make a clear instant.
`timescale 1ns / 1ps

module kwm_queue_table #(
  parameter int ENTRIES = 8,
  parameter int AW      = 3,
  parameter int HW      = 8,
  parameter int FW      = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [HW-1:0] wr_head,
  input  logic [FW-1:0] wr_fill,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [HW-1:0] rd_head,
  output logic [FW-1:0] rd_fill
);

  logic [HW+FW-1:0]   mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [HW+FW-1:0]   rd_raw;
  logic               rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_head, wr_fill};
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // An entry that is not valid reads as an empty queue at slot zero.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (rd_en) begin
      rd_vld <= valid[rd_addr];
    end
  end

  assign rd_head = rd_vld ? rd_raw[HW+FW-1:FW] : '0;
  assign rd_fill = rd_vld ? rd_raw[FW-1:0] : '0;

endmodule

### rtl/k_way_merge_engine.sv
// Merge engine top level: command sequencer, head comparator and queue bookkeeping.
//
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done high and cannot be held off. A clear, or a
// load to a channel number the block does not have, answers in the cycle
// after acceptance; a load answers after passing through its write state. A
// pop walks channels 0 to n-1 (n the active channel count) through one table
// read port, one store read port and one signed comparator: a head-read state
// for every channel, a compare state for each non-empty one, then an end state
// for the pointer update, after which the result register shows the answer.
// busy falls in the cycle that shows done, so the next request may be taken
// there. No clearing pass follows reset. The configuration channel is always
// ready.
`timescale 1ns / 1ps

module k_way_merge_engine #(
  parameter int CHANNELS    = 8,
  parameter int QUEUE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [2:0]  channel,
  input  logic [31:0] key,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] out_key,
  output logic [2:0]  out_channel,
  output logic        last
);

  localparam int CHW = $clog2(CHANNELS);
  localparam int HW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = HW + 1;
  localparam int AW  = $clog2(CHANNELS * QUEUE_DEPTH);
  localparam int TW  = $clog2(CHANNELS * QUEUE_DEPTH + 1);
  localparam int NW  = $clog2(CHANNELS + 1);

  kwm_pkg::state_t state, state_next;

  logic [3:0]         active;
  logic [TW-1:0]      total;
  logic [2:0]         ch_q;
  logic [31:0]        key_q;
  logic [CHW-1:0]     idx;
  logic [CHW-1:0]     last_idx;
  logic [NW-1:0]      n_eff;
  logic               found;
  logic [CHW-1:0]     best_idx;
  logic signed [31:0] best_key;
  logic [HW-1:0]      best_head;
  logic [FW-1:0]      best_fill;
  logic [HW-1:0]      cur_head;
  logic [FW-1:0]      cur_fill;

  logic               scan_last;
  logic               ch_ok;
  logic               full;
  logic [SW-1:0]      tail_sum;
  logic [HW-1:0]      tail_slot;
  logic [SW-1:0]      next_sum;
  logic [HW-1:0]      next_head;

  logic               tbl_clr;
  logic               tbl_wr_en;
  logic [CHW-1:0]     tbl_wr_addr;
  logic [HW-1:0]      tbl_wr_head;
  logic [FW-1:0]      tbl_wr_fill;
  logic               tbl_rd_en;
  logic [CHW-1:0]     tbl_rd_addr;
  logic [HW-1:0]      tbl_head;
  logic [FW-1:0]      tbl_fill;

  logic               st_wr_en;
  logic [AW-1:0]      st_wr_addr;
  logic               st_rd_en;
  logic [AW-1:0]      st_rd_addr;
  logic [31:0]        st_rd_data;

  kwm_queue_table #(
    .ENTRIES (CHANNELS),
    .AW      (CHW),
    .HW      (HW),
    .FW      (FW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .clr     (tbl_clr),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_head (tbl_wr_head),
    .wr_fill (tbl_wr_fill),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_head (tbl_head),
    .rd_fill (tbl_fill)
  );

  kwm_key_store #(
    .DEPTH (CHANNELS * QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (key_q),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  assign busy      = (state != kwm_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // Active count of zero behaves as one; counts beyond the channel count saturate.
  always_comb begin
    if (active == 4'd0) begin
      n_eff = NW'(1);
    end else if (32'(active) > 32'(CHANNELS)) begin
      n_eff = NW'(CHANNELS);
    end else begin
      n_eff = NW'(active);
    end
  end

  assign ch_ok     = 32'(channel) < 32'(CHANNELS);
  assign scan_last = (idx == last_idx);
  assign full      = (tbl_fill >= FW'(QUEUE_DEPTH));

  assign tail_sum  = SW'(tbl_head) + SW'(tbl_fill);
  assign tail_slot = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
                                                    : HW'(tail_sum);
  assign next_sum  = SW'(best_head) + SW'(1);
  assign next_head = (next_sum >= SW'(QUEUE_DEPTH)) ? HW'(next_sum - SW'(QUEUE_DEPTH))
                                                    : HW'(next_sum);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      kwm_pkg::S_IDLE: begin
        if (start) begin
          priority if (mode == kwm_pkg::MODE_CLEAR) begin
            state_next = kwm_pkg::S_IDLE;
          end else if (mode == kwm_pkg::MODE_LOAD) begin
            state_next = ch_ok ? kwm_pkg::S_LD_WR : kwm_pkg::S_IDLE;
          end else begin
            state_next = kwm_pkg::S_SC_HEAD;
          end
        end
      end
      kwm_pkg::S_LD_WR: begin
        state_next = kwm_pkg::S_IDLE;
      end
      kwm_pkg::S_SC_HEAD: begin
        if (tbl_fill != '0) begin
          state_next = kwm_pkg::S_SC_CMP;
        end else if (scan_last) begin
          state_next = kwm_pkg::S_SC_END;
        end
      end
      kwm_pkg::S_SC_CMP: begin
        state_next = scan_last ? kwm_pkg::S_SC_END : kwm_pkg::S_SC_HEAD;
      end
      kwm_pkg::S_SC_END: begin
        state_next = kwm_pkg::S_IDLE;
      end
      default: begin
        state_next = kwm_pkg::S_IDLE;
      end
    endcase
  end

  // Memory port controls.
  always_comb begin
    tbl_clr     = 1'b0;
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = CHW'(ch_q);
    tbl_wr_head = tbl_head;
    tbl_wr_fill = tbl_fill + FW'(1);
    tbl_rd_en   = 1'b0;
    tbl_rd_addr = idx + CHW'(1);
    st_wr_en    = 1'b0;
    st_wr_addr  = AW'(ch_q) * AW'(QUEUE_DEPTH) + AW'(tail_slot);
    st_rd_en    = 1'b0;
    st_rd_addr  = AW'(idx) * AW'(QUEUE_DEPTH) + AW'(tbl_head);
    unique case (state)
      kwm_pkg::S_IDLE: begin
        if (start) begin
          tbl_rd_en   = 1'b1;
          tbl_rd_addr = (mode == kwm_pkg::MODE_LOAD) ? CHW'(channel) : '0;
          tbl_clr     = (mode == kwm_pkg::MODE_CLEAR);
        end
      end
      kwm_pkg::S_LD_WR: begin
        if (!full) begin
          tbl_wr_en = 1'b1;
          st_wr_en  = 1'b1;
        end
      end
      kwm_pkg::S_SC_HEAD: begin
        if (tbl_fill != '0) begin
          st_rd_en = 1'b1;
        end else if (!scan_last) begin
          tbl_rd_en = 1'b1;
        end
      end
      kwm_pkg::S_SC_CMP: begin
        tbl_rd_en = !scan_last;
      end
      kwm_pkg::S_SC_END: begin
        tbl_wr_en   = found;
        tbl_wr_addr = best_idx;
        tbl_wr_head = next_head;
        tbl_wr_fill = best_fill - FW'(1);
      end
      default: begin
        tbl_rd_en = 1'b0;
      end
    endcase
  end

  // Sequencer registers, scan bookkeeping and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= kwm_pkg::S_IDLE;
      done   <= 1'b0;
      total  <= '0;
      active <= kwm_pkg::ACTIVE_RESET;
      found  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        active <= cfg_data;
      end
      unique case (state)
        kwm_pkg::S_IDLE: begin
          if (start) begin
            ch_q     <= channel;
            key_q    <= key;
            idx      <= '0;
            found    <= 1'b0;
            last_idx <= CHW'(n_eff - NW'(1));
            if (mode == kwm_pkg::MODE_CLEAR) begin
              total       <= '0;
              done        <= 1'b1;
              status      <= kwm_pkg::ST_CLEARED;
              out_key     <= '0;
              out_channel <= '0;
              last        <= 1'b0;
            end else if (mode == kwm_pkg::MODE_LOAD && !ch_ok) begin
              done        <= 1'b1;
              status      <= kwm_pkg::ST_OVERFLOW;
              out_key     <= '0;
              out_channel <= '0;
              last        <= 1'b0;
            end
          end
        end
        kwm_pkg::S_LD_WR: begin
          done        <= 1'b1;
          out_key     <= '0;
          out_channel <= '0;
          last        <= 1'b0;
          if (full) begin
            status <= kwm_pkg::ST_OVERFLOW;
          end else begin
            status <= kwm_pkg::ST_LOADED;
            total  <= total + TW'(1);
          end
        end
        kwm_pkg::S_SC_HEAD: begin
          if (tbl_fill != '0) begin
            cur_head <= tbl_head;
            cur_fill <= tbl_fill;
          end else if (!scan_last) begin
            idx <= idx + CHW'(1);
          end
        end
        kwm_pkg::S_SC_CMP: begin
          // A strict compare keeps the lowest channel on equal heads.
          if (!found || ($signed(st_rd_data) < best_key)) begin
            found     <= 1'b1;
            best_idx  <= idx;
            best_key  <= $signed(st_rd_data);
            best_head <= cur_head;
            best_fill <= cur_fill;
          end
          if (!scan_last) begin
            idx <= idx + CHW'(1);
          end
        end
        kwm_pkg::S_SC_END: begin
          done <= 1'b1;
          if (found) begin
            total       <= total - TW'(1);
            status      <= kwm_pkg::ST_POPPED;
            out_key     <= best_key;
            out_channel <= 3'(best_idx);
            last        <= (total == TW'(1));
          end else begin
            status      <= kwm_pkg::ST_EMPTY;
            out_key     <= '0;
            out_channel <= '0;
            last        <= 1'b0;
          end
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

endmodule

### rtl/kwm_checker.sv
// Port-level checker for the merge engine and the bind that attaches it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kwm_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic        last
);

  // The engine is free again in the very cycle that shows a result.
  `KWM_ASSERT(a_done_not_busy, clk, rst, done |-> !busy)

  // Work never ends without a result.
  `KWM_ASSERT(a_busy_end_done, clk, rst, ($fell(busy) && !$past(rst)) |-> done)

  // An accepted request either keeps the engine busy or answers at once.
  `KWM_ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, busy || done)

  // Only a successful pop can mark the final stored element.
  `KWM_ASSERT(a_last_on_pop, clk, rst, (done && last) |-> (status == kwm_pkg::ST_POPPED))

endmodule

bind k_way_merge_engine kwm_checker u_kwm_checker (.*);

### sim/kwm_checker.sv
// Checker for the merge engine: predicts every result from the accepted requests and compares.
`timescale 1ns / 1ps

module kwm_monitor #(
  parameter int CHANNELS    = 8,
  parameter int QUEUE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  mode,
  input  logic [2:0]  channel,
  input  logic [31:0] key,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [31:0] out_key,
  input  logic [2:0]  out_channel,
  input  logic        last,
  output int          fail_count,
  output int          pending_count
);

  localparam int SLOT_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_key;
    logic [2:0]  out_channel;
    logic        last;
  } merge_result_t;

  logic [31:0]       key_store [CHANNELS][QUEUE_DEPTH];
  logic [SLOT_W-1:0] head_slot [CHANNELS];
  logic [SLOT_W:0]   queue_fill [CHANNELS];
  logic [11:0]       keys_held;
  logic [3:0]        active_count;

  merge_result_t expected_results[$];
  merge_result_t predicted;
  merge_result_t oldest;
  int            errors = 0;

  task automatic clear_queues();
    for (int c = 0; c < CHANNELS; c++) begin
      head_slot[c] = '0;
      queue_fill[c] = '0;
    end
    keys_held = '0;
  endtask

  task automatic merge_request(input logic [1:0] m, input logic [2:0] ch,
                               input logic [31:0] k, output merge_result_t r);
    int          n;
    int          c;
    int          slot;
    int          best;
    logic [31:0] best_key;
    bit          found;
    r = '0;
    case (m)
      kwm_pkg::MODE_CLEAR: begin
        clear_queues();
        r.status = kwm_pkg::ST_CLEARED;
      end
      kwm_pkg::MODE_LOAD: begin
        if (ch >= CHANNELS || queue_fill[ch] >= QUEUE_DEPTH) begin
          r.status = kwm_pkg::ST_OVERFLOW;
        end else begin
          slot = (int'(head_slot[ch]) + int'(queue_fill[ch])) % QUEUE_DEPTH;
          key_store[ch][slot] = k;
          queue_fill[ch] = queue_fill[ch] + 1'b1;
          keys_held = keys_held + 1'b1;
          r.status = kwm_pkg::ST_LOADED;
        end
      end
      default: begin
        // Both codes with the high bit set are pops.
        n = active_count;
        if (n == 0) n = 1;
        if (n > CHANNELS) n = CHANNELS;
        found = 1'b0;
        best = 0;
        best_key = '0;
        // Strict less-than keeps the lowest channel on equal heads.
        for (c = 0; c < n; c++) begin
          if (queue_fill[c] != 0 &&
              (!found || $signed(key_store[c][head_slot[c]]) < $signed(best_key))) begin
            found = 1'b1;
            best = c;
            best_key = key_store[c][head_slot[c]];
          end
        end
        if (!found) begin
          r.status = kwm_pkg::ST_EMPTY;
        end else begin
          head_slot[best] = SLOT_W'((int'(head_slot[best]) + 1) % QUEUE_DEPTH);
          queue_fill[best] = queue_fill[best] - 1'b1;
          keys_held = keys_held - 1'b1;
          r.status = kwm_pkg::ST_POPPED;
          r.out_key = best_key;
          r.out_channel = best[2:0];
          r.last = (keys_held == 0);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_queues();
      active_count = kwm_pkg::ACTIVE_RESET;
      expected_results.delete();
    end else begin
      // The result of the previous request is compared before a request taken
      // at the same edge is predicted.
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, status %0d key 0x%08h channel %0d last %0b",
                   $time, status, out_key, out_channel, last);
          errors++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("status", 32'(oldest.status), 32'(status));
          check_field("out_key", oldest.out_key, out_key);
          check_field("out_channel", 32'(oldest.out_channel), 32'(out_channel));
          check_field("last", 32'(oldest.last), 32'(last));
        end
      end
      if (cfg_valid && cfg_ready) active_count = cfg_data;
      if (start && !busy) begin
        merge_request(mode, channel, key, predicted);
        expected_results.insert(expected_results.size(), predicted);
      end
    end
    pending_count <= expected_results.size();
    fail_count <= errors;
  end

endmodule

### sim/tb_k_way_merge_engine.sv
// Testbench top for the merge engine: reset, clock, request and configuration stimulus, verdict.
`timescale 1ns / 1ps

module tb_k_way_merge_engine;

  localparam logic [1:0] MODE_POP    = 2'd2;
  localparam logic [1:0] MODE_POP_HI = 2'd3;
  localparam int         STALL_LIMIT = 2000;
  localparam int         PHASE_ITEMS = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = kwm_pkg::MODE_CLEAR;
  logic [2:0]  channel = '0;
  logic [31:0] key = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;
  logic        done;
  logic [2:0]  status;
  logic [31:0] out_key;
  logic [2:0]  out_channel;
  logic        last;
  int          fail_count;
  int          pending_count;

  bit          no_gaps = 1'b0;
  int          stall_cycles = 0;

  always #4 clk = ~clk;

  k_way_merge_engine #(.CHANNELS(8), .QUEUE_DEPTH(256)) uut (.*);

  kwm_monitor #(.CHANNELS(8), .QUEUE_DEPTH(256)) u_monitor (.*);

  // Ends the run when neither side has moved anything for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Start stays high across back-to-back requests; it drops only for a gap or to settle.
  task automatic issue_request(input logic [1:0] m, input logic [2:0] ch,
                               input logic [31:0] k);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    channel <= ch;
    key <= k;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_active(input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          i;
    int          ph;
    int          pick;
    logic [1:0]  m;
    logic [31:0] k;
    logic [3:0]  setting;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Extremes of the key, bit patterns, equal heads and a pop on empty queues.
    issue_request(MODE_POP, 3'd0, 32'd0);
    issue_request(kwm_pkg::MODE_CLEAR, 3'd7, 32'hffff_ffff);
    issue_request(kwm_pkg::MODE_LOAD, 3'd0, 32'h8000_0000);
    issue_request(kwm_pkg::MODE_LOAD, 3'd7, 32'h7fff_ffff);
    issue_request(kwm_pkg::MODE_LOAD, 3'd3, 32'h0000_0000);
    issue_request(kwm_pkg::MODE_LOAD, 3'd3, 32'hffff_ffff);
    issue_request(kwm_pkg::MODE_LOAD, 3'd2, 32'd5);
    issue_request(kwm_pkg::MODE_LOAD, 3'd6, 32'd5);
    issue_request(kwm_pkg::MODE_LOAD, 3'd5, 32'h5555_5555);
    issue_request(kwm_pkg::MODE_LOAD, 3'd1, 32'haaaa_aaaa);
    issue_request(kwm_pkg::MODE_LOAD, 3'd4, 32'h7fff_ffff);
    issue_request(kwm_pkg::MODE_LOAD, 3'd6, 32'h8000_0000);
    for (i = 0; i < 11; i++) begin
      issue_request((i % 2) ? MODE_POP_HI : MODE_POP, 3'($urandom), $urandom);
    end
    issue_request(kwm_pkg::MODE_LOAD, 3'd1, 32'd1);
    issue_request(kwm_pkg::MODE_CLEAR, 3'd0, 32'd0);
    issue_request(MODE_POP_HI, 3'd0, 32'd0);
    settle();

    // Keys held by inactive channels are skipped until the channel is active again.
    write_active(4'd1);
    issue_request(kwm_pkg::MODE_LOAD, 3'd5, 32'd9);
    issue_request(kwm_pkg::MODE_LOAD, 3'd0, 32'd3);
    issue_request(MODE_POP, 3'd0, 32'd0);
    issue_request(MODE_POP, 3'd0, 32'd0);
    settle();
    write_active(4'd0);
    issue_request(MODE_POP, 3'd0, 32'd0);
    settle();
    write_active(4'd15);
    issue_request(MODE_POP, 3'd0, 32'd0);
    settle();

    // Fill one queue past its depth, drain part of it, then refill across the wrap.
    write_active(4'd8);
    no_gaps = 1'b1;
    for (i = 0; i < 257; i++) issue_request(kwm_pkg::MODE_LOAD, 3'd6, 32'(i * 3 - 384));
    for (i = 0; i < 128; i++) issue_request(MODE_POP, 3'd0, 32'd0);
    for (i = 0; i < 129; i++) issue_request(kwm_pkg::MODE_LOAD, 3'd6, $urandom);
    issue_request(MODE_POP, 3'd0, 32'd0);
    issue_request(kwm_pkg::MODE_CLEAR, 3'd0, 32'd0);
    settle();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: setting = 4'd8;
        1: setting = 4'd1;
        2: setting = 4'd0;
        3: setting = 4'd15;
        4: setting = 4'd3;
        5: setting = 4'd6;
        6: setting = 4'd2;
        default: setting = 4'($urandom_range(0, 15));
      endcase
      write_active(setting);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) m = kwm_pkg::MODE_CLEAR;
        else if (pick < 52) m = kwm_pkg::MODE_LOAD;
        else m = ($urandom_range(0, 4) == 0) ? MODE_POP_HI : MODE_POP;
        // Small keys make equal heads common.
        case ($urandom_range(0, 3))
          0: k = 32'($urandom_range(0, 7)) - 32'd4;
          1: k = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
          default: k = $urandom;
        endcase
        issue_request(m, 3'($urandom_range(0, 7)), k);
      end
      settle();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### k_way_merge_engine.f
+incdir+rtl
rtl/kwm_pkg.sv
rtl/kwm_key_store.sv
rtl/kwm_queue_table.sv
rtl/k_way_merge_engine.sv
rtl/kwm_checker.sv
sim/kwm_checker.sv
sim/tb_k_way_merge_engine.sv
